// File: design/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants and types of the merge sorter with counters.
// ----------------------------------------------------------------------------
package msc_pkg;

	// default capacity of the element store
	localparam int MAX_ITEMS = 32;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int CMP_W   = 13;
	localparam int PART_W  = 7;
	localparam int STEP_W  = 8;

	// one input word as it travels through the queue
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} word_t;

endpackage

// File: design/msc_ram.sv
// ----------------------------------------------------------------------------
// msc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/msc_front.sv
// ----------------------------------------------------------------------------
// msc_front
// Input side: accepts words and holds them in a two-entry queue for the
// sorting engine, so the input can take up to two words while the engine stalls.
// ----------------------------------------------------------------------------
module msc_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [msc_pkg::VALUE_W-1:0]   value,
	input  logic                                 is_last,
	output logic                                 q_valid,
	input  logic                                 q_ready,
	output msc_pkg::word_t                       q_word
);

	msc_pkg::word_t slot_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     fill_q;
	logic           push;
	logic           pop;

	assign in_ready = (fill_q != 2'd2);
	assign q_valid  = (fill_q != 2'd0);
	assign q_word   = slot_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= '{value: value, last: is_last};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: design/msc_back.sv
// ----------------------------------------------------------------------------
// msc_back
// Sorting engine: loads words into the element store, runs a top-down merge
// sort driven by an explicit split stack, and emits the sorted words.
// ----------------------------------------------------------------------------
module msc_back #(
	parameter int MAX_ITEMS = msc_pkg::MAX_ITEMS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_ready,
	input  msc_pkg::word_t                       q_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [msc_pkg::VALUE_W-1:0]   sorted_value,
	output logic                                 is_final,
	output logic [msc_pkg::CMP_W-1:0]            comparisons,
	output logic [msc_pkg::PART_W-1:0]           partitions,
	output logic [msc_pkg::STEP_W-1:0]           steps_taken
);

	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int STK = 2 * AW + 2;
	localparam int SPW = $clog2(STK + 1);
	localparam int SIW = $clog2(STK);
	localparam int VW  = msc_pkg::VALUE_W;

	typedef enum logic [2:0] {ST_LOAD, ST_NODE, ST_MERGE, ST_COPY, ST_EMIT} state_t;

	typedef struct packed {
		logic [AW-1:0] lo;
		logic [AW-1:0] hi;
		logic          done;
	} span_t;

	state_t              state_q, nxt;
	logic [CW-1:0]       cnt_q, cnt_nx, n_q;
	logic [CW-1:0]       i_q, j_q, k_q, i_d, j_d, k_d;
	logic [AW-1:0]       m_lo_q, m_mid_q, m_hi_q;
	logic [SPW-1:0]      sp_q;
	span_t               stk_q [STK];
	span_t               top;
	logic [SIW-1:0]      top_idx;
	logic [AW:0]         sum;
	logic [AW-1:0]       mid;
	logic [msc_pkg::CMP_W-1:0] cmp_q;

	logic                st_we, bf_we;
	logic [AW-1:0]       st_wa, st_ra_a, st_ra_b;
	logic [VW-1:0]       st_wd, st_rd_a, st_rd_b, bf_wd, bf_rd;
	logic                li, rj, take_a, slot_free, out_load;
	logic [CW-1:0]       nm1;

	assign top_idx = SIW'(sp_q - SPW'(1));
	assign top     = stk_q[top_idx];
	assign sum     = {1'b0, top.lo} + {1'b0, top.hi};
	assign mid     = sum[AW:1];
	assign cnt_nx  = cnt_q + CW'(cnt_q < CW'(MAX_ITEMS));
	assign nm1     = n_q - CW'(1);

	// merge decision on the two heads
	assign li     = (i_q <= CW'(m_mid_q));
	assign rj     = (j_q <= CW'(m_hi_q));
	assign take_a = li && (!rj || ($signed(st_rd_a) < $signed(st_rd_b)));
	assign bf_wd  = take_a ? st_rd_a : st_rd_b;

	assign slot_free = !out_valid || out_ready;

	// next-state and datapath control
	always_comb begin
		nxt      = state_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		st_we    = 1'b0;
		st_wa    = k_q[AW-1:0];
		st_wd    = bf_rd;
		bf_we    = 1'b0;
		q_ready  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				q_ready = 1'b1;
				st_wa   = cnt_q[AW-1:0];
				st_wd   = q_word.value;
				if (q_valid) begin
					st_we = (cnt_q < CW'(MAX_ITEMS));
					if (q_word.last) nxt = ST_NODE;
				end
			end
			ST_NODE: begin
				if (sp_q == '0) begin
					k_d = '0;
					nxt = ST_EMIT;
				end else if (top.done && top.lo < top.hi) begin
					i_d = CW'(top.lo);
					j_d = CW'(mid) + CW'(1);
					k_d = CW'(top.lo);
					nxt = ST_MERGE;
				end
			end
			ST_MERGE: begin
				bf_we = 1'b1;
				if (take_a) i_d = i_q + CW'(1);
				else        j_d = j_q + CW'(1);
				k_d = k_q + CW'(1);
				if (k_q == CW'(m_hi_q)) begin
					k_d = CW'(m_lo_q);
					nxt = ST_COPY;
				end
			end
			ST_COPY: begin
				st_we = 1'b1;
				k_d   = k_q + CW'(1);
				if (k_q == CW'(m_hi_q)) nxt = ST_NODE;
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					k_d      = k_q + CW'(1);
					if (k_q == nm1) nxt = ST_LOAD;
				end
			end
			default: nxt = ST_LOAD;
		endcase
	end

	assign st_ra_a = (nxt == ST_MERGE) ? i_d[AW-1:0] : k_d[AW-1:0];
	assign st_ra_b = j_d[AW-1:0];

	// state, indices, split stack and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			n_q       <= '0;
			sp_q      <= '0;
			cmp_q     <= '0;
			out_valid <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			state_q <= nxt;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			unique case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						cnt_q <= cnt_nx;
						if (q_word.last) begin
							cnt_q      <= '0;
							n_q        <= cnt_nx;
							cmp_q      <= '0;
							sp_q       <= SPW'(1);
							stk_q[0]   <= '{lo: '0, hi: AW'(cnt_nx - CW'(1)), done: 1'b0};
						end
					end
				end
				ST_NODE: begin
					if (sp_q != '0) begin
						if (top.lo >= top.hi) begin
							sp_q <= sp_q - SPW'(1);
						end else if (!top.done) begin
							// mark the span, then push right and left halves
							stk_q[top_idx].done        <= 1'b1;
							stk_q[SIW'(sp_q)]          <= '{lo: mid + AW'(1), hi: top.hi,
								done: 1'b0};
							stk_q[SIW'(sp_q + SPW'(1))] <= '{lo: top.lo, hi: mid, done: 1'b0};
							sp_q <= sp_q + SPW'(2);
						end else begin
							m_lo_q  <= top.lo;
							m_mid_q <= mid;
							m_hi_q  <= top.hi;
							sp_q    <= sp_q - SPW'(1);
						end
					end
				end
				ST_MERGE: begin
					if (li && rj) cmp_q <= cmp_q + msc_pkg::CMP_W'(1);
				end
				ST_COPY: begin
				end
				ST_EMIT: begin
				end
				default: begin
				end
			endcase
			// output register
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			sorted_value <= $signed(st_rd_a);
			is_final     <= (k_q == nm1);
			comparisons  <= cmp_q;
			partitions   <= msc_pkg::PART_W'({nm1, 1'b0});
			steps_taken  <= msc_pkg::STEP_W'({2'b00, nm1} + {1'b0, nm1, 1'b0} + (CW+2)'(1));
		end
	end

	// element store, kept twice for two read ports
	msc_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_store_a (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
		.raddr(st_ra_a), .rdata(st_rd_a)
	);

	msc_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_store_b (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
		.raddr(st_ra_b), .rdata(st_rd_b)
	);

	// merge buffer
	msc_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_buffer (
		.clk(clk), .we(bf_we), .waddr(k_q[AW-1:0]), .wdata(bf_wd),
		.raddr(k_d[AW-1:0]), .rdata(bf_rd)
	);

endmodule

// File: design/merge_sort_with_counters.sv
// ----------------------------------------------------------------------------
// merge_sort_with_counters
// Collects signed words until one marked last, sorts them ascending and
// returns them with comparison, partition and step counts.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while in_ready is high into a two-entry
// queue and loaded into the element store while the engine is loading; words
// beyond MAX_ITEMS are dropped. The word marked last starts the sort of the n
// held words. The sort runs on a single merge unit: each merge of a span
// writes its words into the merge buffer and then copies them back to the
// store, with the split stack handled between merges. Results then leave one
// per cycle while out_ready is high through an output register. No new word
// is loaded while a sort runs.
module merge_sort_with_counters #(
	parameter int MAX_ITEMS = msc_pkg::MAX_ITEMS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [msc_pkg::VALUE_W-1:0]   value,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [msc_pkg::VALUE_W-1:0]   sorted_value,
	output logic                                 is_final,
	output logic [msc_pkg::CMP_W-1:0]            comparisons,
	output logic [msc_pkg::PART_W-1:0]           partitions,
	output logic [msc_pkg::STEP_W-1:0]           steps_taken
);

	logic           q_valid;
	logic           q_ready;
	msc_pkg::word_t q_word;

	// input queue
	msc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.value(value), .is_last(is_last),
		.q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
	);

	// sorting engine
	msc_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.sorted_value(sorted_value), .is_final(is_final),
		.comparisons(comparisons), .partitions(partitions),
		.steps_taken(steps_taken)
	);

endmodule

// File: design/msc_checker.sv
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks of the merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
module msc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [msc_pkg::VALUE_W-1:0]        sorted_value,
	input logic                               is_final,
	input logic [msc_pkg::CMP_W-1:0]          comparisons,
	input logic [msc_pkg::PART_W-1:0]         partitions,
	input logic [msc_pkg::STEP_W-1:0]         steps_taken
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sorted_value) && $stable(is_final))
		else $error("result word changed while stalled");

	// step count follows partition count
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (partitions[0] == 1'b0) &&
			(steps_taken == msc_pkg::STEP_W'(partitions[6:1]) * msc_pkg::STEP_W'(3) +
				msc_pkg::STEP_W'(1)))
		else $error("steps_taken does not match partitions");

	// comparison and partition counts are the same on every word of one set
	a_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !is_final |=>
			$stable(comparisons) && $stable(partitions))
		else $error("counters changed within one sorted set");

endmodule

bind merge_sort_with_counters msc_checker u_msc_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_valid), .out_ready(out_ready),
	.sorted_value(sorted_value), .is_final(is_final),
	.comparisons(comparisons), .partitions(partitions),
	.steps_taken(steps_taken)
);
